// ===== design/assert_macros.svh =====
// assertion macros used by the top-level assembler design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/sta_pkg.sv =====
package sta_pkg;
	localparam int IdxW = 16;
	localparam int PosW = 32;
	localparam int MatW = 16;
	localparam int QDepth = 4;
	localparam int QPtrW = 2;
	localparam logic [0:0] RegFaceType = 1'b0;
	localparam logic FaceList = 1'b0;

	typedef struct packed {
		logic [IdxW-1:0] a;
		logic [IdxW-1:0] b;
		logic [IdxW-1:0] c;
		logic [MatW-1:0] mat;
	} tri_t;

	function automatic logic fp_equal(input logic [PosW-1:0] x, input logic [PosW-1:0] y);
		logic [PosW-2:0] mx;
		logic [PosW-2:0] my;
		mx = x[PosW-2:0];
		my = y[PosW-2:0];
		if (mx > 31'h7F800000 || my > 31'h7F800000) return 1'b0;
		if (mx == '0 && my == '0) return 1'b1;
		return x == y;
	endfunction
endpackage

// ===== design/strip_to_triangle_assembler.sv =====
// a triangle enters the queue as its closing vertex is taken; ports show its head
// throughput: one vertex per cycle unless full; the window stage decides one a cycle
// a four-entry triangle queue decouples it from the consumer, full stalls push
// reset: arst_n clears window fill, parity, queue pointers and face_type (list mode)
`include "assert_macros.svh"
module strip_to_triangle_assembler (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [0:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input  logic push,
	output logic full,
	input  logic [sta_pkg::IdxW-1:0] vertex_index,
	input  logic [sta_pkg::PosW-1:0] pos_x,
	input  logic [sta_pkg::PosW-1:0] pos_y,
	input  logic [sta_pkg::PosW-1:0] pos_z,
	input  logic [sta_pkg::MatW-1:0] material,
	input  logic last_in_split,
	output logic empty,
	input  logic pop,
	output logic [sta_pkg::IdxW-1:0] corner_a,
	output logic [sta_pkg::IdxW-1:0] corner_b,
	output logic [sta_pkg::IdxW-1:0] corner_c,
	output logic [sta_pkg::MatW-1:0] tri_material
);
	import sta_pkg::*;

	logic face_type_q;
	logic accept;
	logic emit;
	tri_t tri_w;
	tri_t tri_r;
	logic q_full;

	assign pready = 1'b1;
	assign prdata = (paddr == RegFaceType) ? {31'd0, face_type_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) face_type_q <= FaceList;
		else if (psel && penable && pwrite && paddr == RegFaceType) face_type_q <= pwdata[0];
	end

	assign full = q_full;
	assign accept = push && !q_full;

	sta_front u_front (
		.clk, .arst_n, .face_type(face_type_q), .in_valid(accept),
		.vertex_index, .pos_x, .pos_y, .pos_z, .material, .last_in_split,
		.emit, .tri_out(tri_w)
	);

	sta_queue u_queue (
		.clk, .arst_n, .wr(emit), .wdata(tri_w), .rd(pop), .rdata(tri_r),
		.q_empty(empty), .q_full
	);

	assign corner_a = tri_r.a;
	assign corner_b = tri_r.b;
	assign corner_c = tri_r.c;
	assign tri_material = tri_r.mat;

	`ASSERT_IMPLIES(a_no_emit_when_full, clk, arst_n, q_full, !emit)
	`ASSERT_NEXT(a_push_fills, clk, arst_n, emit && empty, !empty)
	`ASSERT_IMPLIES(a_emit_needs_accept, clk, arst_n, emit, accept)
endmodule

// ===== design/sta_front.sv =====
module sta_front (
	input  logic clk,
	input  logic arst_n,
	input  logic face_type,
	input  logic in_valid,
	input  logic [sta_pkg::IdxW-1:0] vertex_index,
	input  logic [sta_pkg::PosW-1:0] pos_x,
	input  logic [sta_pkg::PosW-1:0] pos_y,
	input  logic [sta_pkg::PosW-1:0] pos_z,
	input  logic [sta_pkg::MatW-1:0] material,
	input  logic last_in_split,
	output logic emit,
	output sta_pkg::tri_t tri_out
);
	import sta_pkg::*;

	logic [IdxW-1:0] idx_q [2];
	logic [PosW-1:0] x_q [2];
	logic [PosW-1:0] y_q [2];
	logic [PosW-1:0] z_q [2];
	logic [1:0] fill_q;
	logic par_q;
	logic degen;
	logic full2;

	function automatic logic same(input logic [PosW-1:0] ax, input logic [PosW-1:0] ay,
			input logic [PosW-1:0] az, input logic [PosW-1:0] bx,
			input logic [PosW-1:0] by, input logic [PosW-1:0] bz);
		return fp_equal(ax, bx) && fp_equal(ay, by) && fp_equal(az, bz);
	endfunction

	assign full2 = fill_q[1];
	assign degen = same(x_q[0], y_q[0], z_q[0], x_q[1], y_q[1], z_q[1])
		|| same(x_q[0], y_q[0], z_q[0], pos_x, pos_y, pos_z)
		|| same(x_q[1], y_q[1], z_q[1], pos_x, pos_y, pos_z);

	always_comb begin
		emit = in_valid && full2 && (face_type == FaceList || !degen);
		tri_out.b = idx_q[0];
		tri_out.mat = material;
		if (face_type == FaceList || !par_q) begin
			tri_out.a = idx_q[1];
			tri_out.c = vertex_index;
		end else begin
			tri_out.a = vertex_index;
			tri_out.c = idx_q[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			par_q <= 1'b0;
		end else if (in_valid) begin
			if (last_in_split) begin
				fill_q <= '0;
				par_q <= 1'b0;
			end else begin
				if (full2 && face_type == FaceList) fill_q <= '0;
				else if (!full2) fill_q <= fill_q + 2'd1;
				if (full2 && face_type != FaceList) par_q <= !par_q;
			end
		end
	end

	// window shift; list mode leaves the window untouched when full
	always_ff @(posedge clk) begin
		if (in_valid) begin
			if (!full2) begin
				idx_q[fill_q[0]] <= vertex_index;
				x_q[fill_q[0]] <= pos_x;
				y_q[fill_q[0]] <= pos_y;
				z_q[fill_q[0]] <= pos_z;
			end else if (face_type != FaceList) begin
				idx_q[0] <= idx_q[1];
				x_q[0] <= x_q[1];
				y_q[0] <= y_q[1];
				z_q[0] <= z_q[1];
				idx_q[1] <= vertex_index;
				x_q[1] <= pos_x;
				y_q[1] <= pos_y;
				z_q[1] <= pos_z;
			end
		end
	end
endmodule

// ===== design/sta_queue.sv =====
module sta_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  sta_pkg::tri_t wdata,
	input  logic rd,
	output sta_pkg::tri_t rdata,
	output logic q_empty,
	output logic q_full
);
	import sta_pkg::*;

	tri_t mem_q [QDepth];
	logic [QPtrW-1:0] wp_q;
	logic [QPtrW-1:0] rp_q;
	logic [QPtrW:0] cnt_q;
	logic do_wr;
	logic do_rd;

	assign q_empty = cnt_q == '0;
	assign q_full = cnt_q == (QPtrW+1)'(QDepth);
	assign do_wr = wr && !q_full;
	assign do_rd = rd && !q_empty;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) wp_q <= wp_q + 1'b1;
			if (do_rd) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (QPtrW+1)'(do_wr) - (QPtrW+1)'(do_rd);
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wp_q] <= wdata;
	end
endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
	import sta_pkg::*;

	typedef struct {
		logic [IdxW-1:0] idx;
		logic [PosW-1:0] x;
		logic [PosW-1:0] y;
		logic [PosW-1:0] z;
		logic [MatW-1:0] mat;
		logic            last;
	} vertex_t;

	class triangle_scoreboard;
		logic            mode;
		logic [IdxW-1:0] win_idx [2];
		logic [PosW-1:0] win_x [2];
		logic [PosW-1:0] win_y [2];
		logic [PosW-1:0] win_z [2];
		int              fill;
		logic            parity;
		tri_t            pending_tris [$];
		int              n_vertices;
		int              n_triangles;
		int              n_skipped;
		int              n_errors;

		function new();
			mode = FaceList;
			fill = 0;
			parity = 1'b0;
			n_vertices = 0;
			n_triangles = 0;
			n_skipped = 0;
			n_errors = 0;
		endfunction

		function bit ieee_eq(logic [PosW-1:0] p, logic [PosW-1:0] q);
			if (p[30:0] > 31'h7F800000 || q[30:0] > 31'h7F800000) return 1'b0;
			if (p[30:0] == 31'h0 && q[30:0] == 31'h0) return 1'b1;
			return p == q;
		endfunction

		function bit same_spot(logic [PosW-1:0] ax, logic [PosW-1:0] ay,
				logic [PosW-1:0] az, logic [PosW-1:0] bx, logic [PosW-1:0] by,
				logic [PosW-1:0] bz);
			return ieee_eq(ax, bx) && ieee_eq(ay, by) && ieee_eq(az, bz);
		endfunction

		function void expect_tri(tri_t t);
			pending_tris = {pending_tris, t};
		endfunction

		function void shift_in(vertex_t v);
			int slot;
			if (fill < 2) begin
				slot = fill;
				fill++;
			end else begin
				win_idx[0] = win_idx[1];
				win_x[0] = win_x[1];
				win_y[0] = win_y[1];
				win_z[0] = win_z[1];
				slot = 1;
			end
			win_idx[slot] = v.idx;
			win_x[slot] = v.x;
			win_y[slot] = v.y;
			win_z[slot] = v.z;
		endfunction

		function void note_vertex(vertex_t v);
			tri_t t;
			bit degen;
			n_vertices++;
			if (fill >= 2) begin
				if (mode == FaceList) begin
					t.a = win_idx[1];
					t.b = win_idx[0];
					t.c = v.idx;
					t.mat = v.mat;
					expect_tri(t);
					fill = 0;
				end else begin
					degen = same_spot(win_x[0], win_y[0], win_z[0], win_x[1], win_y[1], win_z[1])
						|| same_spot(win_x[0], win_y[0], win_z[0], v.x, v.y, v.z)
						|| same_spot(win_x[1], win_y[1], win_z[1], v.x, v.y, v.z);
					if (!degen) begin
						t.a = parity ? v.idx : win_idx[1];
						t.c = parity ? win_idx[1] : v.idx;
						t.b = win_idx[0];
						t.mat = v.mat;
						expect_tri(t);
					end else begin
						n_skipped++;
					end
					parity = ~parity;
					shift_in(v);
				end
			end else begin
				shift_in(v);
			end
			if (v.last) begin
				fill = 0;
				parity = 1'b0;
			end
		endfunction

		function void check_triangle(tri_t got);
			tri_t want;
			if (pending_tris.size() == 0) begin
				n_errors++;
				if (n_errors <= 10)
					$display("unexpected triangle a=%h b=%h c=%h mat=%h",
						got.a, got.b, got.c, got.mat);
				return;
			end
			want = pending_tris.pop_front();
			n_triangles++;
			if (got !== want) begin
				n_errors++;
				if (n_errors <= 10)
					$display("triangle mismatch: expected a=%h b=%h c=%h mat=%h, got a=%h b=%h c=%h mat=%h",
						want.a, want.b, want.c, want.mat, got.a, got.b, got.c, got.mat);
			end
		endfunction
	endclass

	logic            clk;
	logic            arst_n;
	logic            psel;
	logic            penable;
	logic            pwrite;
	logic [0:0]      paddr;
	logic [31:0]     pwdata;
	logic [31:0]     prdata;
	logic            pready;
	logic            push;
	logic            full;
	logic [IdxW-1:0] vertex_index;
	logic [PosW-1:0] pos_x;
	logic [PosW-1:0] pos_y;
	logic [PosW-1:0] pos_z;
	logic [MatW-1:0] material;
	logic            last_in_split;
	logic            empty;
	logic            pop;
	logic [IdxW-1:0] corner_a;
	logic [IdxW-1:0] corner_b;
	logic [IdxW-1:0] corner_c;
	logic [MatW-1:0] tri_material;

	triangle_scoreboard sb;
	int gap_pct;
	int stall_pct;
	int n_strip_phases;
	int n_list_phases;

	strip_to_triangle_assembler dut (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("** strip_to_triangle_assembler: FAILED **");
		$finish;
	end

	// transaction monitor on both sides, sampled at the edge
	always @(posedge clk) begin
		vertex_t v;
		tri_t t;
		if (arst_n) begin
			if (push && !full) begin
				v.idx = vertex_index;
				v.x = pos_x;
				v.y = pos_y;
				v.z = pos_z;
				v.mat = material;
				v.last = last_in_split;
				sb.note_vertex(v);
			end
			if (pop && !empty) begin
				t.a = corner_a;
				t.b = corner_b;
				t.c = corner_c;
				t.mat = tri_material;
				sb.check_triangle(t);
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic send_vertex(vertex_t v);
		int n;
		if ($urandom_range(99) < gap_pct) begin
			push <= 1'b0;
			n = $urandom_range(3, 1);
			repeat (n) @(posedge clk);
		end
		push <= 1'b1;
		vertex_index <= v.idx;
		pos_x <= v.x;
		pos_y <= v.y;
		pos_z <= v.z;
		material <= v.mat;
		last_in_split <= v.last;
		do @(posedge clk); while (full);
	endtask

	task automatic go_idle();
		push <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		go_idle();
		while (sb.pending_tris.size() != 0) @(posedge clk);
		// a vertex with no triangle may still be in the window stage
		repeat (4) @(posedge clk);
	endtask

	task automatic write_face_type(logic [31:0] value);
		drain();
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= RegFaceType;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.mode = value[0];
		if (value[0] == FaceList) n_list_phases++;
		else n_strip_phases++;
		@(posedge clk);
		if (prdata[0] !== value[0]) begin
			sb.n_errors++;
			$display("face_type readback %b, wrote %b", prdata[0], value[0]);
		end
	endtask

	function automatic logic [PosW-1:0] rand_coord();
		case ($urandom_range(9))
			0: return 32'h0000_0000;
			1: return 32'h8000_0000;
			2: return 32'h3F80_0000;
			3: return 32'h7FC0_0001;
			4: return 32'h7F80_0000;
			5: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic vertex_t mk(int idx, logic [PosW-1:0] x, logic [PosW-1:0] y,
			logic [PosW-1:0] z, int mat, bit last);
		vertex_t v;
		v.idx = IdxW'(idx);
		v.x = x;
		v.y = y;
		v.z = z;
		v.mat = MatW'(mat);
		v.last = last;
		return v;
	endfunction

	task automatic send_split(int len);
		vertex_t v;
		vertex_t prev;
		int mat;
		mat = $urandom_range(65535);
		for (int i = 0; i < len; i++) begin
			v = mk($urandom_range(65535), rand_coord(), rand_coord(), rand_coord(),
				mat, i == len - 1);
			// sometimes repeat a position to hit skipped windows
			if (i > 0 && $urandom_range(7) == 0) begin
				v.x = prev.x;
				v.y = prev.y;
				v.z = prev.z;
			end
			if ($urandom_range(15) == 0) v.mat = MatW'($urandom_range(65535));
			send_vertex(v);
			prev = v;
		end
	endtask

	initial begin
		int sent;
		sb = new();
		gap_pct = 0;
		stall_pct = 0;
		n_strip_phases = 0;
		n_list_phases = 0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		push = 1'b0;
		vertex_index = '0;
		pos_x = '0;
		pos_y = '0;
		pos_z = '0;
		material = '0;
		last_in_split = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// list mode from reset: full group, extremes, short split, trailing pair
		send_vertex(mk(16'hFFFF, 32'hFFFFFFFF, 32'h0, 32'h0, 16'hFFFF, 0));
		send_vertex(mk(0, 32'h0, 32'hFFFFFFFF, 32'h0, 0, 0));
		send_vertex(mk(16'h1234, 32'h0, 32'h0, 32'hFFFFFFFF, 16'hA5A5, 0));
		send_vertex(mk(5, 32'h3F800000, 32'h3F800000, 32'h3F800000, 7, 0));
		send_vertex(mk(6, 32'h3F800000, 32'h3F800000, 32'h3F800000, 7, 1));
		send_vertex(mk(9, 32'h1, 32'h2, 32'h3, 3, 1));
		// split left open across a mode change
		send_vertex(mk(20, 32'h40000000, 32'h0, 32'h0, 1, 0));
		send_vertex(mk(21, 32'h40400000, 32'h0, 32'h0, 1, 0));
		write_face_type(1);
		// strip: plain windows, +0 vs -0 skip, NaN never matches
		send_vertex(mk(22, 32'h40800000, 32'h0, 32'h0, 1, 0));
		send_vertex(mk(23, 32'h40A00000, 32'h0, 32'h0, 1, 0));
		send_vertex(mk(24, 32'h0, 32'h0, 32'h0, 2, 0));
		send_vertex(mk(25, 32'h80000000, 32'h80000000, 32'h0, 2, 0));
		send_vertex(mk(26, 32'h7FC00000, 32'h0, 32'h0, 2, 0));
		send_vertex(mk(27, 32'h7FC00000, 32'h0, 32'h0, 2, 0));
		send_vertex(mk(28, 32'h7F800000, 32'h0, 32'h0, 2, 0));
		send_vertex(mk(29, 32'h7F800000, 32'h0, 32'h0, 2, 1));
		send_vertex(mk(30, 32'h1, 32'h1, 32'h1, 4, 0));
		send_vertex(mk(31, 32'h2, 32'h1, 32'h1, 4, 1));
		send_vertex(mk(32, 32'h1, 32'h1, 32'h1, 5, 0));
		send_vertex(mk(33, 32'h2, 32'h1, 32'h1, 5, 0));
		send_vertex(mk(34, 32'h3, 32'h1, 32'h1, 5, 0));
		write_face_type(0);
		send_vertex(mk(35, 32'h4, 32'h1, 32'h1, 6, 0));
		write_face_type(1);
		send_vertex(mk(36, 32'h5, 32'h1, 32'h1, 6, 1));

		sent = 0;
		for (int phase = 0; phase < 8; phase++) begin
			case (phase % 4)
				0: begin gap_pct = 0; stall_pct = 0; end
				1: begin gap_pct = 63; stall_pct = 0; end
				2: begin gap_pct = 0; stall_pct = 63; end
				default: begin gap_pct = 25; stall_pct = 25; end
			endcase
			write_face_type((phase == 0) ? 32'hFFFF_FFFE : (phase == 1) ? 32'h1 :
				{$urandom} & 32'hFFFF_FFFF);
			while (sent < (phase + 1) * 200) begin
				int len;
				len = ($urandom_range(9) == 0) ? $urandom_range(2, 1) : $urandom_range(20, 3);
				send_split(len);
				sent += len;
				if (sent > 1000 && sent < 1030) begin
					// let the queue run dry before going on
					go_idle();
					while (sb.pending_tris.size() != 0) @(posedge clk);
				end
			end
		end

		drain();
		repeat (10) @(posedge clk);
		$display("vertices %0d, triangles %0d, skipped strip windows %0d",
			sb.n_vertices, sb.n_triangles, sb.n_skipped);
		$display("list phases %0d, strip phases %0d, mismatches %0d",
			n_list_phases, n_strip_phases, sb.n_errors);
		if (sb.n_errors == 0 && sb.pending_tris.size() == 0) begin
			$display("** strip_to_triangle_assembler: PASSED **");
		end else begin
			$display("** strip_to_triangle_assembler: FAILED **");
		end
		$finish;
	end
endmodule
